// ===== hw/rtl/lsvc_pkg.sv =====
// ----------------------------------------------------------------------------
// lsvc_pkg
// Shared types, widths and the exponential table builder for the classifier.
// ----------------------------------------------------------------------------
package lsvc_pkg;

  localparam int ADDR_W        = 6;
  localparam int COEF_W        = 32;
  localparam int WEIGHT_BASE   = 16;
  localparam int WEIGHT_STRIDE = 8;
  localparam int SCORE_W       = 52;
  localparam int SUM_W         = 20;
  localparam int CONF_W        = 17;
  localparam int DIVIDEND_W    = 33;
  localparam int CLASS_W       = 3;

  typedef struct packed {
    logic                     req_type;
    logic [ADDR_W-1:0]        coef_index;
    logic signed [COEF_W-1:0] coef_value;
    logic                     reading_valid;
    logic [7:0]               heart_rate;
    logic [6:0]               spo2_pct;
    logic [7:0]               resp_rate;
    logic [8:0]               systolic;
    logic [8:0]               diastolic;
  } in_item_t;

  typedef struct packed {
    logic [CLASS_W-1:0] class_index;
    logic [CONF_W-1:0]  confidence;
    logic               invalid_reading;
  } out_item_t;

  // Entry idx of the exponential table in Q1.16. The ratio between entries is
  // exp(-step), taken from a 12-term Taylor series in Q0.32, and t is the step
  // in Q0.32 scaled by 16.
  function automatic logic [CONF_W-1:0] exp_entry(input logic [63:0] t,
                                                   input int unsigned idx);
    logic [63:0] term;
    logic [63:0] r;
    logic [63:0] e;
    term = 64'd1 << 32;
    r    = 64'd1 << 32;
    e    = 64'd1 << 32;
    for (int n = 1; n <= 12; n++) begin
      term = (term * t) >> 32;
      unique case (n)
        2:       term = term / 64'd2;
        3:       term = term / 64'd3;
        4:       term = term / 64'd4;
        5:       term = term / 64'd5;
        6:       term = term / 64'd6;
        7:       term = term / 64'd7;
        8:       term = term / 64'd8;
        9:       term = term / 64'd9;
        10:      term = term / 64'd10;
        11:      term = term / 64'd11;
        12:      term = term / 64'd12;
        default: term = term;
      endcase
      if ((n % 2) == 1) begin
        r = r - term;
      end else begin
        r = r + term;
      end
    end
    for (int unsigned k = 1; k <= idx; k++) begin
      e = (e * r + (64'd1 << 31)) >> 32;
    end
    return CONF_W'((e + 64'd32768) >> 16);
  endfunction

endpackage

// ===== hw/rtl/lsvc_coef_mem.sv =====
// ----------------------------------------------------------------------------
// lsvc_coef_mem
// Coefficient store, one write port and one read port with registered data.
// ----------------------------------------------------------------------------
module lsvc_coef_mem import lsvc_pkg::*; (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [ADDR_W-1:0]        waddr_i,
  input  logic signed [COEF_W-1:0] wdata_i,
  input  logic [ADDR_W-1:0]        raddr_i,
  output logic signed [COEF_W-1:0] rdata_o
);

  logic signed [COEF_W-1:0] mem_q [2**ADDR_W];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_o <= mem_q[raddr_i];
  end

endmodule

// ===== hw/rtl/lsvc_div.sv =====
// ----------------------------------------------------------------------------
// lsvc_div
// Restoring divider that produces one quotient bit per cycle.
// ----------------------------------------------------------------------------
module lsvc_div import lsvc_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start_i,
  input  logic [DIVIDEND_W-1:0] dividend_i,
  input  logic [SUM_W-1:0]      divisor_i,
  output logic                  done_o,
  output logic [DIVIDEND_W-1:0] quot_o
);

  localparam int CNT_W = $clog2(DIVIDEND_W + 1);

  logic [CNT_W-1:0]      cnt_q, cnt_d;
  logic                  busy_q, busy_d;
  logic                  done_q, done_d;
  logic [DIVIDEND_W-1:0] quot_q, quot_d;
  logic [SUM_W-1:0]      den_q, den_d;
  logic [SUM_W:0]        rem_q, rem_d;
  logic [SUM_W:0]        rem_sh;

  always_comb begin
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    quot_d = quot_q;
    den_d  = den_q;
    rem_d  = rem_q;
    rem_sh = {rem_q[SUM_W-1:0], quot_q[DIVIDEND_W-1]};
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      quot_d = dividend_i;
      den_d  = divisor_i;
      rem_d  = '0;
    end else if (busy_q) begin
      // The dividend shifts out at the top while quotient bits enter below.
      if (rem_sh >= {1'b0, den_q}) begin
        rem_d  = rem_sh - {1'b0, den_q};
        quot_d = {quot_q[DIVIDEND_W-2:0], 1'b1};
      end else begin
        rem_d  = rem_sh;
        quot_d = {quot_q[DIVIDEND_W-2:0], 1'b0};
      end
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == CNT_W'(DIVIDEND_W - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      busy_q <= busy_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quot_q <= quot_d;
    den_q  <= den_d;
    rem_q  <= rem_d;
  end

  assign done_o = done_q;
  assign quot_o = quot_q;

endmodule

// ===== hw/rtl/linear_svm_vitals_classifier.sv =====
// ----------------------------------------------------------------------------
// linear_svm_vitals_classifier
// Linear one-vs-rest vital-sign classifier with a loadable coefficient table.
// ----------------------------------------------------------------------------
// A load beat writes one coefficient word and leaves the block idle. A classify
// beat with a valid reading is worked through one shared signed multiplier and
// one coefficient read port under a small sequencer: per feature it reads the
// mean and the scale, then multiplies and stores the standardized value; per
// class it reads the bias, then multiplies and accumulates one weight per
// feature; it then adds one exponential term per class to the sum and finishes
// in the bit-serial divider. The next beat is taken once the result has moved
// to the output register, while a stalled result holds the block in its last
// state. An invalid reading goes straight to the result state. The block takes
// no new beat while a classification is in progress. The coefficient table has
// no reset value and every word that a classification reads must be loaded
// first.
module linear_svm_vitals_classifier import lsvc_pkg::*; #(
  parameter int NUM_FEATURES    = 5,
  parameter int NUM_CLASSES     = 4,
  parameter int EXP_TABLE_DEPTH = 256
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  in_item_t           in_data_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output out_item_t          out_data_o,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [CLASS_W-1:0] cfg_data_i
);

  localparam int F_W  = (NUM_FEATURES > 1) ? $clog2(NUM_FEATURES) : 1;
  localparam int C_W  = (NUM_CLASSES > 1) ? $clog2(NUM_CLASSES) : 1;
  localparam int EI_W = $clog2(EXP_TABLE_DEPTH);
  localparam logic [63:0] EXP_T = (64'd1 << 36) / EXP_TABLE_DEPTH;

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_FMEAN = 4'd1;
  localparam logic [3:0] S_FRSD  = 4'd2;
  localparam logic [3:0] S_FMUL  = 4'd3;
  localparam logic [3:0] S_FZ    = 4'd4;
  localparam logic [3:0] S_CBIAS = 4'd5;
  localparam logic [3:0] S_CLOAD = 4'd6;
  localparam logic [3:0] S_CMUL  = 4'd7;
  localparam logic [3:0] S_CACC  = 4'd8;
  localparam logic [3:0] S_EXP   = 4'd9;
  localparam logic [3:0] S_DIV   = 4'd10;
  localparam logic [3:0] S_DIVW  = 4'd11;
  localparam logic [3:0] S_DONE  = 4'd12;

  logic [3:0]                state_q, state_d;
  logic [F_W-1:0]            f_q, f_d;
  logic [C_W-1:0]            c_q, c_d;
  logic [CLASS_W-1:0]        fallback_q;
  in_item_t                  item_q;
  logic signed [COEF_W-1:0]  mean_q;
  logic                      rsd_zero_q;
  logic signed [65:0]        prod_q;
  logic signed [COEF_W-1:0]  z_q [NUM_FEATURES];
  logic signed [SCORE_W-1:0] acc_q;
  logic signed [SCORE_W-1:0] score_q [NUM_CLASSES];
  logic signed [SCORE_W-1:0] best_q;
  logic [C_W-1:0]            best_idx_q;
  logic [SUM_W-1:0]          sum_q;
  out_item_t                 res_q, res_d;
  logic                      out_valid_q;
  out_item_t                 out_q;

  logic                      in_acc;
  logic                      mem_we;
  logic [ADDR_W-1:0]         raddr;
  logic signed [COEF_W-1:0]  rdata;
  logic [8:0]                x_sel;
  logic signed [33:0]        diff;
  logic signed [33:0]        mul_a;
  logic signed [COEF_W-1:0]  mul_b;
  logic signed [COEF_W-1:0]  z_sat;
  logic signed [SCORE_W-1:0] acc_new;
  logic [F_W-1:0]            wf;
  logic [SCORE_W-1:0]        score_gap;
  logic [30:0]               eprod;
  logic [CONF_W-1:0]         exp_term;
  logic [CONF_W-1:0]         exp_lut [EXP_TABLE_DEPTH];
  logic                      div_start;
  logic                      div_done;
  logic [DIVIDEND_W-1:0]     div_quot;
  logic                      out_free;

  for (genvar i = 0; i < EXP_TABLE_DEPTH; i++) begin : g_exp
    assign exp_lut[i] = exp_entry(EXP_T, i);
  end

  assign in_stall_o  = (state_q != S_IDLE);
  assign in_acc      = in_valid_i && !in_stall_o;
  assign mem_we      = in_acc && !in_data_i.req_type;
  assign cfg_ready_o = 1'b1;
  assign out_free    = !out_valid_q || !out_stall_i;

  lsvc_coef_mem u_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (in_data_i.coef_index),
    .wdata_i (in_data_i.coef_value),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  // Features past the fifth read as zero.
  always_comb begin
    priority if (int'(f_q) == 0) x_sel = {1'b0, item_q.heart_rate};
    else if (int'(f_q) == 1)     x_sel = {2'b0, item_q.spo2_pct};
    else if (int'(f_q) == 2)     x_sel = {1'b0, item_q.resp_rate};
    else if (int'(f_q) == 3)     x_sel = item_q.systolic;
    else if (int'(f_q) == 4)     x_sel = item_q.diastolic;
    else                         x_sel = '0;
  end

  assign diff = $signed({9'd0, x_sel, 16'd0}) - $signed({{2{mean_q[COEF_W-1]}}, mean_q});
  assign wf   = (state_q == S_CACC) ? f_q + 1'b1 : f_q;

  always_comb begin
    unique case (state_q)
      S_FMEAN: raddr = ADDR_W'(f_q);
      S_FRSD:  raddr = ADDR_W'(NUM_FEATURES) + ADDR_W'(f_q);
      S_CBIAS: raddr = ADDR_W'(2 * NUM_FEATURES) + ADDR_W'(c_q);
      default: raddr = ADDR_W'(WEIGHT_BASE) + ADDR_W'(WEIGHT_STRIDE * int'(c_q))
                       + ADDR_W'(wf);
    endcase
  end

  // The one multiplier serves standardization and the dot products.
  always_comb begin
    if (state_q == S_FMUL) begin
      mul_a = diff;
      mul_b = rdata;
    end else begin
      mul_a = 34'(rdata);
      mul_b = z_q[f_q];
    end
  end

  // Saturate the standardized feature to the signed 32-bit range.
  always_comb begin
    if (prod_q[65:47] == {19{prod_q[65]}}) begin
      z_sat = prod_q[47:16];
    end else if (prod_q[65]) begin
      z_sat = {1'b1, {(COEF_W-1){1'b0}}};
    end else begin
      z_sat = {1'b0, {(COEF_W-1){1'b1}}};
    end
  end

  assign acc_new = acc_q + SCORE_W'($signed(prod_q[65:16]));

  assign score_gap = best_q - score_q[c_q];
  assign eprod     = 31'(score_gap[19:0]) * 31'(EXP_TABLE_DEPTH);
  assign exp_term  = (score_gap[SCORE_W-1:20] == '0) ? exp_lut[eprod[20 +: EI_W]] : '0;

  assign div_start = (state_q == S_DIV);

  lsvc_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i ((DIVIDEND_W'(1) << 32) + DIVIDEND_W'(sum_q >> 1)),
    .divisor_i  (sum_q),
    .done_o     (div_done),
    .quot_o     (div_quot)
  );

  always_comb begin
    state_d = state_q;
    f_d     = f_q;
    c_d     = c_q;
    res_d   = res_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_acc && in_data_i.req_type) begin
          if (!in_data_i.reading_valid) begin
            res_d.class_index     = fallback_q;
            res_d.confidence      = '0;
            res_d.invalid_reading = 1'b1;
            state_d               = S_DONE;
          end else begin
            f_d     = '0;
            state_d = S_FMEAN;
          end
        end
      end
      S_FMEAN: state_d = S_FRSD;
      S_FRSD:  state_d = S_FMUL;
      S_FMUL:  state_d = S_FZ;
      S_FZ: begin
        if (f_q == F_W'(NUM_FEATURES - 1)) begin
          f_d     = '0;
          c_d     = '0;
          state_d = S_CBIAS;
        end else begin
          f_d     = f_q + 1'b1;
          state_d = S_FMEAN;
        end
      end
      S_CBIAS: state_d = S_CLOAD;
      S_CLOAD: state_d = S_CMUL;
      S_CMUL:  state_d = S_CACC;
      S_CACC: begin
        if (f_q == F_W'(NUM_FEATURES - 1)) begin
          f_d = '0;
          if (c_q == C_W'(NUM_CLASSES - 1)) begin
            c_d     = '0;
            state_d = S_EXP;
          end else begin
            c_d     = c_q + 1'b1;
            state_d = S_CBIAS;
          end
        end else begin
          f_d     = f_q + 1'b1;
          state_d = S_CMUL;
        end
      end
      S_EXP: begin
        if (c_q == C_W'(NUM_CLASSES - 1)) begin
          state_d = S_DIV;
        end else begin
          c_d = c_q + 1'b1;
        end
      end
      S_DIV: state_d = S_DIVW;
      S_DIVW: begin
        if (div_done) begin
          res_d.class_index     = CLASS_W'(best_idx_q);
          res_d.confidence      = div_quot[CONF_W-1:0];
          res_d.invalid_reading = 1'b0;
          state_d               = S_DONE;
        end
      end
      S_DONE: begin
        if (out_free) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      f_q         <= '0;
      c_q         <= '0;
      fallback_q  <= CLASS_W'(3);
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      f_q     <= f_d;
      c_q     <= c_d;
      if (cfg_valid_i && cfg_ready_o) begin
        fallback_q <= cfg_data_i;
      end
      if (state_q == S_DONE && out_free) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
    if (in_acc) begin
      item_q <= in_data_i;
    end
    if (state_q == S_FRSD) begin
      mean_q <= rdata;
    end
    if (state_q == S_FMUL) begin
      rsd_zero_q <= (rdata == '0);
    end
    if (state_q == S_FMUL || state_q == S_CMUL) begin
      prod_q <= mul_a * mul_b;
    end
    if (state_q == S_FZ) begin
      z_q[f_q] <= rsd_zero_q ? '0 : z_sat;
    end
    if (state_q == S_CLOAD) begin
      acc_q <= SCORE_W'(rdata);
    end
    if (state_q == S_CACC) begin
      acc_q <= acc_new;
      if (f_q == F_W'(NUM_FEATURES - 1)) begin
        score_q[c_q] <= acc_new;
        // A later class wins only with a strictly higher score.
        if (c_q == '0 || acc_new > best_q) begin
          best_q     <= acc_new;
          best_idx_q <= c_q;
        end
        if (c_q == C_W'(NUM_CLASSES - 1)) begin
          sum_q <= '0;
        end
      end
    end
    if (state_q == S_EXP) begin
      sum_q <= sum_q + SUM_W'(exp_term);
    end
    if (state_q == S_DONE && out_free) begin
      out_q <= res_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule
